@@ hdl/lot_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LRU order tracker package
// Shared types, operation and status codes for the recency list.
// ----------------------------------------------------------------------------
package lot_pkg;

   localparam int SLOT_W        = 6;
   localparam int PTR_W         = 7;
   localparam int COUNT_W       = 32;
   localparam int SLOTS_DEFAULT = 64;

   typedef enum logic [1:0] {
      FUNC_TOUCH  = 2'd0,
      FUNC_INSERT = 2'd1,
      FUNC_REMOVE = 2'd2,
      FUNC_EVICT  = 2'd3
   } func_type;

   typedef enum logic [1:0] {
      STATUS_OK    = 2'd0,
      STATUS_STATE = 2'd1,
      STATUS_EMPTY = 2'd2
   } status_type;

   typedef struct packed {
      func_type            func;
      logic [SLOT_W-1:0]   slot;
   } req_type;

   typedef struct packed {
      status_type          status;
      logic                victim_valid;
      logic [SLOT_W-1:0]   victim_slot;
      logic [PTR_W-1:0]    head_slot;
      logic [PTR_W-1:0]    tail_slot;
      logic [PTR_W-1:0]    list_length;
      logic [COUNT_W-1:0]  eviction_total;
   } rsp_type;

   typedef struct packed {
      logic busy;
      logic move;
   } core_stat_type;

endpackage

@@ hdl/lru_order_tracker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LRU order tracker
// Recency list over a pool of slots with touch, insert, remove and evict.
// ----------------------------------------------------------------------------
// Requests arrive on the req_ channel as an operation and a slot; each request
// yields exactly one response on the rsp_ channel with the status, the victim
// of an evict, the new head and tail, the list length and the eviction total.
// Both channels use a valid/ready handshake and a transfer happens when both
// are high at a rising clock edge.
// The link memories are read at the edge that accepts a request; the list is
// updated and the response is registered together, at the edge at which the
// update stage advances, which it does once the response register is empty
// or rsp_ready takes the waiting response; rsp_valid then rises.
// One request is taken per cycle unless held off. A touch that moves a slot
// to the front needs two link writes per memory, so it holds off the next
// request as it advances. The response register lets the next request enter
// while a response waits; once both the response register and the update
// stage are full, req_ready drops until rsp_ready takes the waiting response.
// Reset empties the list and clears the counters and the linked marks at once;
// the link memories need no clearing, so requests are taken right after reset.
// ----------------------------------------------------------------------------
module lru_order_tracker #(
   parameter int SLOTS = lot_pkg::SLOTS_DEFAULT
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  lot_pkg::req_type req_payload,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output lot_pkg::rsp_type rsp_payload
);

   lot_pkg::core_stat_type core_stat;
   lot_pkg::rsp_type       result;
   lot_pkg::rsp_type       rsp_payload_ff;
   logic                   rsp_valid_ff;
   logic                   adv_en;
   logic                   acc_en;

   assign adv_en    = core_stat.busy && (!rsp_valid_ff || rsp_ready);
   assign req_ready = (!core_stat.busy || adv_en) && !(adv_en && core_stat.move);
   assign acc_en    = req_valid && req_ready;

   lot_core #(.SLOTS(SLOTS)) u_core (
      .clock     (clock),
      .reset     (reset),
      .acc_en    (acc_en),
      .req_item  (req_payload),
      .adv_en    (adv_en),
      .core_stat (core_stat),
      .result    (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv_en) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (adv_en) begin
         rsp_payload_ff <= result;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

endmodule

@@ hdl/lot_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port with a registered read.
// ----------------------------------------------------------------------------
module lot_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ hdl/lot_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LRU order tracker list core
// Link memories, head and tail pointers, counters and the update, with a second write pass for a move to the front.
// ----------------------------------------------------------------------------
module lot_core #(
   parameter int SLOTS = lot_pkg::SLOTS_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   acc_en,
   input  lot_pkg::req_type       req_item,
   input  logic                   adv_en,
   output lot_pkg::core_stat_type core_stat,
   output lot_pkg::rsp_type       result
);

   localparam int IDX_W = $clog2(SLOTS);
   localparam int PW    = lot_pkg::PTR_W;
   localparam int SW    = lot_pkg::SLOT_W;
   localparam int CW    = lot_pkg::COUNT_W;
   localparam logic [PW-1:0] NIL = PW'(SLOTS);

   logic                 s1_valid_ff;
   lot_pkg::func_type    s1_func_ff;
   logic [SW-1:0]        s1_slot_ff;
   logic [PW-1:0]        head_ff;
   logic [PW-1:0]        tail_ff;
   logic [PW-1:0]        length_ff;
   logic [CW-1:0]        evict_ff;
   logic [SLOTS-1:0]     mark_ff;
   logic                 fix_ff;
   logic [PW-1:0]        fix_slot_ff;
   logic [PW-1:0]        fix_head_ff;
   logic                 byp_prev_hit_ff;
   logic [PW-1:0]        byp_prev_ff;
   logic                 byp_next_hit_ff;
   logic [PW-1:0]        byp_next_ff;

   logic [PW-1:0]        prev_rd;
   logic [PW-1:0]        next_rd;
   logic [PW-1:0]        rd_ptr;
   logic [IDX_W-1:0]     rd_idx;
   logic [PW-1:0]        tail_rd;

   logic [PW-1:0]        prev_link;
   logic [PW-1:0]        next_link;
   logic [PW-1:0]        slot_ptr;
   logic                 in_range;
   logic                 linked;
   logic [PW-1:0]        tgt_ptr;
   logic [PW-1:0]        up_ptr;
   logic [PW-1:0]        dn_ptr;
   logic                 do_unlink;
   logic                 do_link;
   logic                 do_move;

   logic [PW-1:0]        head_nx;
   logic [PW-1:0]        tail_nx;
   logic [PW-1:0]        length_nx;
   logic [CW-1:0]        evict_nx;
   lot_pkg::status_type  status_nx;
   logic                 victim_nx;
   logic [SW-1:0]        victim_slot_nx;
   logic                 mark_we;
   logic                 mark_val;

   logic                 s1_prev_we;
   logic [PW-1:0]        s1_prev_addr;
   logic [PW-1:0]        s1_prev_data;
   logic                 s1_next_we;
   logic [PW-1:0]        s1_next_addr;
   logic [PW-1:0]        s1_next_data;

   logic                 prev_we;
   logic [IDX_W-1:0]     prev_waddr;
   logic [PW-1:0]        prev_wdata;
   logic                 next_we;
   logic [IDX_W-1:0]     next_waddr;
   logic [PW-1:0]        next_wdata;

   lot_ram #(.WIDTH(PW), .DEPTH(SLOTS)) u_prev_ram (
      .clock   (clock),
      .wr_en   (prev_we),
      .wr_addr (prev_waddr),
      .wr_data (prev_wdata),
      .rd_en   (acc_en),
      .rd_addr (rd_idx),
      .rd_data (prev_rd)
   );

   lot_ram #(.WIDTH(PW), .DEPTH(SLOTS)) u_next_ram (
      .clock   (clock),
      .wr_en   (next_we),
      .wr_addr (next_waddr),
      .wr_data (next_wdata),
      .rd_en   (acc_en),
      .rd_addr (rd_idx),
      .rd_data (next_rd)
   );

   always_comb begin
      prev_link = byp_prev_hit_ff ? byp_prev_ff : prev_rd;
      next_link = byp_next_hit_ff ? byp_next_ff : next_rd;
      slot_ptr  = PW'(s1_slot_ff);
      in_range  = slot_ptr < NIL;
      linked    = in_range && mark_ff[s1_slot_ff[IDX_W-1:0]];
      tgt_ptr   = (s1_func_ff == lot_pkg::FUNC_EVICT) ? tail_ff : slot_ptr;
      // The head's back link and the tail's forward link are never trusted.
      up_ptr    = (tgt_ptr == head_ff) ? NIL : prev_link;
      dn_ptr    = (tgt_ptr == tail_ff) ? NIL : next_link;

      do_unlink      = 1'b0;
      do_link        = 1'b0;
      do_move        = 1'b0;
      status_nx      = lot_pkg::STATUS_OK;
      victim_nx      = 1'b0;
      victim_slot_nx = '0;
      length_nx      = length_ff;
      evict_nx       = evict_ff;
      mark_we        = 1'b0;
      mark_val       = 1'b0;

      case (s1_func_ff)
         lot_pkg::FUNC_EVICT: begin
            if (tail_ff != NIL) begin
               do_unlink      = 1'b1;
               victim_nx      = 1'b1;
               victim_slot_nx = tail_ff[SW-1:0];
               evict_nx       = evict_ff + CW'(1);
               length_nx      = length_ff - PW'(1);
               mark_we        = 1'b1;
            end else begin
               status_nx = lot_pkg::STATUS_EMPTY;
            end
         end
         lot_pkg::FUNC_INSERT: begin
            if (!in_range || linked) begin
               status_nx = lot_pkg::STATUS_STATE;
            end else begin
               do_link   = 1'b1;
               length_nx = length_ff + PW'(1);
               mark_we   = 1'b1;
               mark_val  = 1'b1;
            end
         end
         lot_pkg::FUNC_REMOVE: begin
            if (!linked) begin
               status_nx = lot_pkg::STATUS_STATE;
            end else begin
               do_unlink = 1'b1;
               length_nx = length_ff - PW'(1);
               mark_we   = 1'b1;
            end
         end
         lot_pkg::FUNC_TOUCH: begin
            if (!linked) begin
               status_nx = lot_pkg::STATUS_STATE;
            end else if (slot_ptr != head_ff) begin
               do_move = 1'b1;
            end
         end
         default: begin
            status_nx = lot_pkg::STATUS_STATE;
         end
      endcase

      head_nx      = head_ff;
      tail_nx      = tail_ff;
      s1_prev_we   = 1'b0;
      s1_prev_addr = dn_ptr;
      s1_prev_data = up_ptr;
      s1_next_we   = 1'b0;
      s1_next_addr = up_ptr;
      s1_next_data = dn_ptr;

      if (do_unlink || do_move) begin
         if (up_ptr != NIL) begin
            s1_next_we = 1'b1;
         end else begin
            head_nx = dn_ptr;
         end
         if (dn_ptr != NIL) begin
            s1_prev_we = 1'b1;
         end else begin
            tail_nx = up_ptr;
         end
      end
      if (do_move) begin
         head_nx = slot_ptr;
      end
      if (do_link) begin
         s1_next_we   = 1'b1;
         s1_next_addr = slot_ptr;
         s1_next_data = head_ff;
         s1_prev_addr = head_ff;
         s1_prev_data = slot_ptr;
         if (head_ff != NIL) begin
            s1_prev_we = 1'b1;
         end else begin
            tail_nx = slot_ptr;
         end
         head_nx = slot_ptr;
      end
   end

   // The second half of a move to the front is written in the following cycle.
   always_comb begin
      if (fix_ff) begin
         prev_we    = 1'b1;
         prev_waddr = fix_head_ff[IDX_W-1:0];
         prev_wdata = fix_slot_ff;
         next_we    = 1'b1;
         next_waddr = fix_slot_ff[IDX_W-1:0];
         next_wdata = fix_head_ff;
      end else begin
         prev_we    = adv_en && s1_prev_we;
         prev_waddr = s1_prev_addr[IDX_W-1:0];
         prev_wdata = s1_prev_data;
         next_we    = adv_en && s1_next_we;
         next_waddr = s1_next_addr[IDX_W-1:0];
         next_wdata = s1_next_data;
      end
   end

   always_comb begin
      tail_rd = adv_en ? tail_nx : tail_ff;
      rd_ptr  = (req_item.func == lot_pkg::FUNC_EVICT) ? tail_rd : PW'(req_item.slot);
      rd_idx  = (rd_ptr < NIL) ? rd_ptr[IDX_W-1:0] : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         fix_ff      <= 1'b0;
         head_ff     <= NIL;
         tail_ff     <= NIL;
         length_ff   <= '0;
         evict_ff    <= '0;
         mark_ff     <= '0;
      end else begin
         if (acc_en) begin
            s1_valid_ff <= 1'b1;
         end else if (adv_en) begin
            s1_valid_ff <= 1'b0;
         end
         fix_ff <= adv_en && do_move;
         if (adv_en) begin
            head_ff   <= head_nx;
            tail_ff   <= tail_nx;
            length_ff <= length_nx;
            evict_ff  <= evict_nx;
            if (mark_we) begin
               mark_ff[tgt_ptr[IDX_W-1:0]] <= mark_val;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (acc_en) begin
         s1_func_ff      <= req_item.func;
         s1_slot_ff      <= req_item.slot;
         byp_prev_hit_ff <= prev_we && (prev_waddr == rd_idx);
         byp_prev_ff     <= prev_wdata;
         byp_next_hit_ff <= next_we && (next_waddr == rd_idx);
         byp_next_ff     <= next_wdata;
      end
      if (adv_en) begin
         fix_slot_ff <= slot_ptr;
         fix_head_ff <= head_ff;
      end
   end

   assign core_stat.busy = s1_valid_ff;
   assign core_stat.move = s1_valid_ff && do_move;

   assign result.status         = status_nx;
   assign result.victim_valid   = victim_nx;
   assign result.victim_slot    = victim_slot_nx;
   assign result.head_slot      = head_nx;
   assign result.tail_slot      = tail_nx;
   assign result.list_length    = length_nx;
   assign result.eviction_total = evict_nx;

endmodule

@@ hdl/lot_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LRU order tracker checker
// Port-level assertions on the response channel, bound to the top level.
// ----------------------------------------------------------------------------
module lot_checker #(
   parameter int SLOTS = lot_pkg::SLOTS_DEFAULT
) (
   input logic             clock,
   input logic             reset,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input lot_pkg::rsp_type rsp_payload
);

   localparam logic [lot_pkg::PTR_W-1:0] NIL = lot_pkg::PTR_W'(SLOTS);

   a_reset_idle: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid right after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_payload))
      else $error("stalled response changed");

   a_empty_agree: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((rsp_payload.head_slot == NIL) == (rsp_payload.list_length == '0))
                 && ((rsp_payload.tail_slot == NIL) == (rsp_payload.list_length == '0)))
      else $error("head, tail and length disagree on an empty list");

   a_length_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_payload.list_length <= NIL)
      else $error("list length beyond the pool size");

   a_victim_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.victim_valid |-> rsp_payload.status == lot_pkg::STATUS_OK)
      else $error("victim reported with an error status");

endmodule

bind lru_order_tracker lot_checker #(.SLOTS(SLOTS)) u_lot_checker (
   .clock       (clock),
   .reset       (reset),
   .rsp_valid   (rsp_valid),
   .rsp_ready   (rsp_ready),
   .rsp_payload (rsp_payload)
);
